/* rtl/wall_follow_pd_steering_macros.svh */
// Assertion macros shared by the wall-follow steering RTL.
`ifndef WALL_FOLLOW_PD_STEERING_MACROS_SVH
`define WALL_FOLLOW_PD_STEERING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define WFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wfs check failed");
// Next-cycle implication, disabled while reset is asserted.
`define WFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wfs check failed");
`else
`define WFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/wfs_pkg.sv */
// Shared types and constants of the wall-follow PD steering block.
package wfs_pkg;

	localparam int VALID_LIMIT_MM = 2000;
	localparam int SPEED_MAX      = 127;

	localparam int DIST_W     = 16;
	localparam int SPEED_W    = 7;
	localparam int SPD_W      = SPEED_W + 3;
	localparam int GAIN_W     = 16;
	localparam int TICK_W     = 16;
	localparam int ERR_W      = 17;
	localparam int DERIV_W    = ERR_W + 1;
	localparam int PKP_W      = GAIN_W + 1 + ERR_W;
	localparam int PKD_W      = GAIN_W + 1 + DERIV_W;
	localparam int SUM_W      = PKD_W + 1;
	localparam int FRAC_BITS  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIST_W-1:0]  RST_STOP_DIST = 16'd152;
	localparam logic [DIST_W-1:0]  RST_TARGET    = 16'd152;
	localparam logic [SPEED_W-1:0] RST_BASE      = 7'd80;
	localparam logic [TICK_W-1:0]  RST_MAX_TICKS = 16'd500;
	localparam logic [GAIN_W-1:0]  RST_KP        = 16'd128;
	localparam logic [GAIN_W-1:0]  RST_KD        = 16'd26;

	typedef enum logic [1:0] {
		CAUSE_RUN     = 2'd0,
		CAUSE_FRONT   = 2'd1,
		CAUSE_TIMEOUT = 2'd2
	} cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STOP_DIST = 3'd0,
		REG_TARGET    = 3'd1,
		REG_BASE      = 3'd2,
		REG_MAX_TICKS = 3'd3,
		REG_KP        = 3'd4,
		REG_KD        = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DIST_W-1:0]  stop_dist_mm;
		logic [DIST_W-1:0]  target_dist_mm;
		logic [SPEED_W-1:0] base_speed;
		logic [TICK_W-1:0]  max_ticks;
		logic [GAIN_W-1:0]  kp_gain;
		logic [GAIN_W-1:0]  kd_gain;
	} cfg_t;

	typedef struct packed {
		logic              mode;
		logic [DIST_W-1:0] front_mm;
		logic [DIST_W-1:0] left_mm;
		logic              left_present;
	} req_t;

	typedef struct packed {
		cause_t                    cause;
		logic signed [ERR_W-1:0]   err;
		logic signed [DERIV_W-1:0] deriv;
	} trk_t;

	typedef struct packed {
		cause_t                  cause;
		logic signed [PKP_W-1:0] p_kp;
		logic signed [PKD_W-1:0] p_kd;
	} prod_t;

endpackage

/* rtl/wall_follow_pd_steering.sv */
// Top level of the wall-follow PD steering block.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, mode, front_mm,        | request in
//          | left_mm, left_present                      |
//  out     | out_valid, out_stall, left_speed,          | result out
//          | right_speed, stop_cause                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | write in
//
// A request sits in the input register; tracking, the PD products and the
// clamps run in one pass to the result register, which sets out_valid; one
// request per cycle can flow while out_stall is low.
// The move state updates as the request moves to the result register.
// Reset (arst_n low) empties both registers, clears the move state and loads
// the register defaults. A stalled result holds; in_stall rises only when
// the input register is full behind it. cfg_ready is always high.
module wall_follow_pd_steering (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [wfs_pkg::DIST_W-1:0]       front_mm,
	input  logic [wfs_pkg::DIST_W-1:0]       left_mm,
	input  logic                             left_present,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wfs_pkg::SPEED_W-1:0]      left_speed,
	output logic [wfs_pkg::SPEED_W-1:0]      right_speed,
	output logic [1:0]                       stop_cause,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	wfs_pkg::cfg_t  cfg;
	wfs_pkg::req_t  req_s1;
	wfs_pkg::trk_t  trk;
	wfs_pkg::prod_t prod;

	logic valid_s1;
	logic out_valid_q;
	logic free_o;
	logic free_1;
	logic commit;

	// A register may load when it is empty or when its content moves on.
	assign free_o = !out_valid_q || !out_stall;
	assign free_1 = !valid_s1 || free_o;
	// The request in the input register advances and commits move state.
	assign commit = valid_s1 && free_o;

	assign in_stall  = !free_1;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_1) begin
				valid_s1 <= in_valid;
			end
			if (free_o) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture the request payload; hold it while the stage is blocked.
	always_ff @(posedge clk) begin
		if (free_1) begin
			req_s1.mode         <= mode;
			req_s1.front_mm     <= front_mm;
			req_s1.left_mm      <= left_mm;
			req_s1.left_present <= left_present;
		end
	end

	wfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wfs_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req_s1 (req_s1),
		.commit (commit),
		.trk    (trk)
	);

	wfs_pd_mult u_mult (
		.cfg  (cfg),
		.trk  (trk),
		.prod (prod)
	);

	wfs_drive u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.load        (free_o),
		.prod        (prod),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.stop_cause  (stop_cause)
	);

endmodule

/* rtl/wfs_cfg_regs.sv */
// Configuration register file of the wall-follow steering block.
module wfs_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [wfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wfs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output wfs_pkg::cfg_t                    cfg
);

	wfs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_dist_mm   <= wfs_pkg::RST_STOP_DIST;
			cfg_q.target_dist_mm <= wfs_pkg::RST_TARGET;
			cfg_q.base_speed     <= wfs_pkg::RST_BASE;
			cfg_q.max_ticks      <= wfs_pkg::RST_MAX_TICKS;
			cfg_q.kp_gain        <= wfs_pkg::RST_KP;
			cfg_q.kd_gain        <= wfs_pkg::RST_KD;
		end else if (cfg_valid) begin
			case (wfs_pkg::reg_idx_t'(cfg_index))
				wfs_pkg::REG_STOP_DIST: cfg_q.stop_dist_mm   <= cfg_data;
				wfs_pkg::REG_TARGET:    cfg_q.target_dist_mm <= cfg_data;
				wfs_pkg::REG_BASE:      cfg_q.base_speed     <= cfg_data[wfs_pkg::SPEED_W-1:0];
				wfs_pkg::REG_MAX_TICKS: cfg_q.max_ticks      <= cfg_data;
				wfs_pkg::REG_KP:        cfg_q.kp_gain        <= cfg_data;
				wfs_pkg::REG_KD:        cfg_q.kd_gain        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/wfs_track.sv */
// Move tracker: stop decisions, wall error, derivative and move state.
`include "wall_follow_pd_steering_macros.svh"
module wfs_track (
	input  logic          clk,
	input  logic          arst_n,
	input  wfs_pkg::cfg_t cfg,
	input  wfs_pkg::req_t req_s1,
	input  logic          commit,
	output wfs_pkg::trk_t trk
);

	logic signed [wfs_pkg::ERR_W-1:0]   prev_err_q;
	logic [wfs_pkg::TICK_W-1:0]         tick_q;
	logic                               fin_q;
	wfs_pkg::cause_t                    cause_q;

	logic signed [wfs_pkg::ERR_W-1:0]   eff_prev;
	logic [wfs_pkg::TICK_W-1:0]         eff_tick;
	logic                               eff_fin;
	wfs_pkg::cause_t                    eff_cause;
	logic                               timeout;
	logic                               front_hit;
	logic                               left_ok;
	logic                               running;
	logic signed [wfs_pkg::ERR_W-1:0]   err_now;
	logic signed [wfs_pkg::DERIV_W-1:0] deriv_now;
	wfs_pkg::cause_t                    cause_now;

	// A new move clears the history before the tick is judged.
	always_comb begin
		eff_prev  = req_s1.mode ? '0 : prev_err_q;
		eff_tick  = req_s1.mode ? '0 : tick_q;
		eff_fin   = req_s1.mode ? 1'b0 : fin_q;
		eff_cause = req_s1.mode ? wfs_pkg::CAUSE_RUN : cause_q;
	end

	assign timeout   = (eff_tick >= cfg.max_ticks);
	assign front_hit = (req_s1.front_mm < wfs_pkg::DIST_W'(wfs_pkg::VALID_LIMIT_MM)) &&
			(req_s1.front_mm <= cfg.stop_dist_mm);
	assign left_ok   = req_s1.left_present &&
			(req_s1.left_mm < wfs_pkg::DIST_W'(wfs_pkg::VALID_LIMIT_MM));
	assign running   = !eff_fin && !timeout && !front_hit;

	always_comb begin
		err_now = '0;
		if (left_ok) begin
			err_now = $signed({1'b0, cfg.target_dist_mm}) - $signed({1'b0, req_s1.left_mm});
		end
		deriv_now = {err_now[wfs_pkg::ERR_W-1], err_now} -
				{eff_prev[wfs_pkg::ERR_W-1], eff_prev};
	end

	always_comb begin
		if (eff_fin) begin
			cause_now = eff_cause;
		end else if (timeout) begin
			cause_now = wfs_pkg::CAUSE_TIMEOUT;
		end else if (front_hit) begin
			cause_now = wfs_pkg::CAUSE_FRONT;
		end else begin
			cause_now = wfs_pkg::CAUSE_RUN;
		end
	end

	// Move state advances only when the request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			tick_q     <= '0;
			fin_q      <= 1'b0;
			cause_q    <= wfs_pkg::CAUSE_RUN;
		end else if (commit) begin
			if (running) begin
				prev_err_q <= err_now;
				tick_q     <= (&eff_tick) ? eff_tick : eff_tick + 1'b1;
				fin_q      <= 1'b0;
				cause_q    <= wfs_pkg::CAUSE_RUN;
			end else begin
				prev_err_q <= eff_prev;
				tick_q     <= eff_tick;
				fin_q      <= 1'b1;
				cause_q    <= cause_now;
			end
		end
	end

	assign trk.cause = cause_now;
	assign trk.err   = err_now;
	assign trk.deriv = deriv_now;

	`WFS_ASSERT_NEXT(a_fin_holds, clk, arst_n, commit && fin_q && !req_s1.mode, fin_q)
	`WFS_ASSERT_NEXT(a_tick_monotone, clk, arst_n, commit && !req_s1.mode, tick_q >= $past(tick_q))
	`WFS_ASSERT_NEXT(a_stop_keeps_tick, clk, arst_n, commit && !running, tick_q == $past(eff_tick))

endmodule

/* rtl/wfs_pd_mult.sv */
// PD product logic: gain times error and gain times derivative.
module wfs_pd_mult (
	input  wfs_pkg::cfg_t  cfg,
	input  wfs_pkg::trk_t  trk,
	output wfs_pkg::prod_t prod
);

	logic signed [wfs_pkg::PKP_W-1:0] kp_x;
	logic signed [wfs_pkg::PKP_W-1:0] err_x;
	logic signed [wfs_pkg::PKD_W-1:0] kd_x;
	logic signed [wfs_pkg::PKD_W-1:0] deriv_x;

	// Gains are unsigned; operands are extended to the product width.
	assign kp_x    = {{(wfs_pkg::PKP_W-wfs_pkg::GAIN_W){1'b0}}, cfg.kp_gain};
	assign err_x   = {{(wfs_pkg::PKP_W-wfs_pkg::ERR_W){trk.err[wfs_pkg::ERR_W-1]}},
			trk.err};
	assign kd_x    = {{(wfs_pkg::PKD_W-wfs_pkg::GAIN_W){1'b0}}, cfg.kd_gain};
	assign deriv_x = {{(wfs_pkg::PKD_W-wfs_pkg::DERIV_W){trk.deriv[wfs_pkg::DERIV_W-1]}},
			trk.deriv};

	assign prod.cause = trk.cause;
	assign prod.p_kp  = kp_x * err_x;
	assign prod.p_kd  = kd_x * deriv_x;

endmodule

/* rtl/wfs_drive.sv */
// Drive stage: sum, truncate, clamp and the result register.
`include "wall_follow_pd_steering_macros.svh"
module wfs_drive (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wfs_pkg::cfg_t                cfg,
	input  logic                         load,
	input  wfs_pkg::prod_t               prod,
	output logic [wfs_pkg::SPEED_W-1:0]  left_speed,
	output logic [wfs_pkg::SPEED_W-1:0]  right_speed,
	output logic [1:0]                   stop_cause
);

	logic signed [wfs_pkg::SUM_W-1:0] sum;
	logic signed [wfs_pkg::SUM_W-1:0] biased;
	logic signed [wfs_pkg::SUM_W-1:0] corr_w;
	logic signed [wfs_pkg::SUM_W-1:0] base_w;
	logic signed [wfs_pkg::SPD_W-1:0] corr_c;
	logic signed [wfs_pkg::SPD_W-1:0] base_n;
	logic signed [wfs_pkg::SPD_W-1:0] ls_w;
	logic signed [wfs_pkg::SPD_W-1:0] rs_w;
	logic [wfs_pkg::SPEED_W-1:0]      ls_c;
	logic [wfs_pkg::SPEED_W-1:0]      rs_c;
	logic                             halted;
	logic [wfs_pkg::SPEED_W-1:0]      left_speed_q;
	logic [wfs_pkg::SPEED_W-1:0]      right_speed_q;
	wfs_pkg::cause_t                  cause_q;

	assign halted = (prod.cause != wfs_pkg::CAUSE_RUN);

	always_comb begin
		sum    = {{(wfs_pkg::SUM_W-wfs_pkg::PKP_W){prod.p_kp[wfs_pkg::PKP_W-1]}},
				prod.p_kp} +
			{{(wfs_pkg::SUM_W-wfs_pkg::PKD_W){prod.p_kd[wfs_pkg::PKD_W-1]}},
				prod.p_kd};
		// Bias negatives so the arithmetic shift truncates toward zero.
		biased = sum[wfs_pkg::SUM_W-1] ?
				sum + wfs_pkg::SUM_W'((1 << wfs_pkg::FRAC_BITS) - 1) : sum;
		corr_w = biased >>> wfs_pkg::FRAC_BITS;
		base_w = {{(wfs_pkg::SUM_W-wfs_pkg::SPEED_W){1'b0}}, cfg.base_speed};
		base_n = {{(wfs_pkg::SPD_W-wfs_pkg::SPEED_W){1'b0}}, cfg.base_speed};
		if (corr_w > base_w) begin
			corr_c = base_n;
		end else if (corr_w < -base_w) begin
			corr_c = -base_n;
		end else begin
			corr_c = corr_w[wfs_pkg::SPD_W-1:0];
		end
		ls_w = base_n - corr_c;
		rs_w = base_n + corr_c;
		if (ls_w < 0) begin
			ls_c = '0;
		end else if (ls_w > wfs_pkg::SPD_W'(wfs_pkg::SPEED_MAX)) begin
			ls_c = wfs_pkg::SPEED_W'(wfs_pkg::SPEED_MAX);
		end else begin
			ls_c = ls_w[wfs_pkg::SPEED_W-1:0];
		end
		if (rs_w < 0) begin
			rs_c = '0;
		end else if (rs_w > wfs_pkg::SPD_W'(wfs_pkg::SPEED_MAX)) begin
			rs_c = wfs_pkg::SPEED_W'(wfs_pkg::SPEED_MAX);
		end else begin
			rs_c = rs_w[wfs_pkg::SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cause_q <= prod.cause;
			if (!halted) begin
				left_speed_q  <= ls_c;
				right_speed_q <= rs_c;
			end else begin
				left_speed_q  <= '0;
				right_speed_q <= '0;
			end
		end
	end

	assign left_speed  = left_speed_q;
	assign right_speed = right_speed_q;
	assign stop_cause  = cause_q;

	`WFS_ASSERT_NEXT(a_stop_zero, clk, arst_n, load && halted, left_speed_q == '0 && right_speed_q == '0)

endmodule
